### src/mfs_pkg.sv
// mfs_pkg: shared types, codes and sizes for the multilevel feedback scheduler.
// No dependencies; imported by mfs_queue and multilevel_feedback_scheduler.
`timescale 1ns / 1ps

package mfs_pkg;

    localparam int ID_W          = 4;
    localparam int LVL_W         = 2;
    localparam int OP_W          = 2;
    localparam int NUM_TASKS_DEF = 16;
    localparam int NQ            = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_SCHED = 2'd0;
    localparam logic [OP_W-1:0] OP_WAKE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SETUP = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // levels
    localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
    localparam logic [LVL_W-1:0] LVL_2 = 2'd2;
    localparam logic [LVL_W-1:0] LVL_3 = 2'd3;

    typedef logic [1:0] t_qsel;

    // queue select: queue index is level minus one
    localparam t_qsel Q_LOW  = 2'd0;
    localparam t_qsel Q_MID  = 2'd1;
    localparam t_qsel Q_HIGH = 2'd2;

    // one step request for the shared pointer unit
    typedef struct packed {
        logic  en;
        logic  push;
        t_qsel sel;
    } t_qcmd;

    // queue occupancy flags, bit i is queue i
    typedef struct packed {
        logic [NQ-1:0] nempty;
        logic [NQ-1:0] full;
    } t_qstat;

endpackage

### src/multilevel_feedback_scheduler.sv
// multilevel_feedback_scheduler: top level, request sequencer and task level tables.
// Depends on mfs_pkg and mfs_queue (which uses mfs_ram).
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ----------------------------------------
// request  in         i_valid / o_ready    i_opcode i_task_id i_task_blocked
//                                          i_base_level i_start_level
// result   out        o_valid / i_ready    o_next_task o_next_valid
//
// Sequence: one request at a time. A schedule passes the requeue step, the
// pop step, the RAM read and the result, in that order; when all queues are empty
// no pop is made and the RAM read is skipped. Wake and setup use the request step
// and the result; a no-op goes straight to the result. The steps are set by the
// single shared pointer step unit and the registered read port of the queue RAMs.
// Reset: synchronous, active low; queues empty, all task levels and bases level 1.
// Stalls: the result is held in an output register until transferred; o_ready
// rises again the cycle after.

module multilevel_feedback_scheduler #(
    parameter int NUM_TASKS = mfs_pkg::NUM_TASKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mfs_pkg::OP_W-1:0]   i_opcode,
    input  logic [mfs_pkg::ID_W-1:0]   i_task_id,
    input  logic                       i_task_blocked,
    input  logic [mfs_pkg::LVL_W-1:0]  i_base_level,
    input  logic [mfs_pkg::LVL_W-1:0]  i_start_level,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mfs_pkg::ID_W-1:0]   o_next_task,
    output logic                       o_next_valid
);
    import mfs_pkg::*;

    // only ids that fit the id field can reach the tables
    localparam int TW  = (NUM_TASKS < (1 << ID_W)) ? NUM_TASKS : (1 << ID_W);
    localparam int TIW = $clog2(TW);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REQ  = 5'b00010,
        S_POP  = 5'b00100,
        S_RD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic [OP_W-1:0]  r_op;
    logic [ID_W-1:0]  r_id;
    logic             r_blk;
    logic [LVL_W-1:0] r_base;
    logic [LVL_W-1:0] r_start;

    // result register
    logic [ID_W-1:0] r_next_task, n_next_task;
    logic            r_next_valid, n_next_valid;

    // level tables, reset to level 1
    logic [LVL_W-1:0] r_lvl_tbl  [TW];
    logic [LVL_W-1:0] r_base_tbl [TW];

    t_qcmd           w_cmd;
    t_qstat          w_stat;
    logic [ID_W-1:0] w_rdata;

    logic             w_in_range;
    logic [TIW-1:0]   w_tidx;
    logic [LVL_W-1:0] w_cur_lvl;
    logic [LVL_W-1:0] w_req_lvl;
    logic             w_lvl_we;
    logic [LVL_W-1:0] w_lvl_wdata;
    logic             w_base_we;
    logic             w_accept;

    function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] v);
        clamp_level = (v == '0) ? LVL_1 : v;
    endfunction

    assign w_accept   = i_valid && o_ready;
    assign w_in_range = (32'(r_id) < NUM_TASKS);
    assign w_tidx     = r_id[TIW-1:0];
    assign w_cur_lvl  = r_lvl_tbl[w_tidx];

    // feedback rule: 3 drops to 2, 2 drops to 1, 1 returns to its base
    always_comb begin
        case (w_cur_lvl)
            LVL_3:   w_req_lvl = LVL_2;
            LVL_2:   w_req_lvl = LVL_1;
            default: w_req_lvl = r_base_tbl[w_tidx];
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_next_task  = r_next_task;
        n_next_valid = r_next_valid;
        w_cmd        = '{en: 1'b0, push: 1'b0, sel: Q_LOW};
        w_lvl_we     = 1'b0;
        w_lvl_wdata  = w_req_lvl;
        w_base_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_next_task  = '0;
                    n_next_valid = 1'b0;
                    n_state      = (i_opcode == OP_NOP) ? S_OUT : S_REQ;
                end
            end
            S_REQ: begin
                n_state = S_OUT;
                unique case (r_op)
                    OP_SCHED: begin
                        // requeue the running task unless blocked or idle task
                        if (!r_blk && (r_id != '0) && w_in_range) begin
                            w_lvl_we  = 1'b1;
                            w_cmd.en   = 1'b1;
                            w_cmd.push = 1'b1;
                            w_cmd.sel  = t_qsel'(w_req_lvl - LVL_1);
                        end
                        n_state = S_POP;
                    end
                    OP_WAKE: begin
                        w_cmd.en   = w_in_range;
                        w_cmd.push = 1'b1;
                        w_cmd.sel  = Q_HIGH;
                    end
                    OP_SETUP: begin
                        w_lvl_we    = w_in_range;
                        w_base_we   = w_in_range;
                        w_lvl_wdata = clamp_level(r_start);
                    end
                    default: begin
                    end
                endcase
            end
            S_POP: begin
                // highest nonempty queue wins; none leaves the zero result
                w_cmd.en   = |w_stat.nempty;
                w_cmd.push = 1'b0;
                if (w_stat.nempty[Q_HIGH]) begin
                    w_cmd.sel = Q_HIGH;
                end else if (w_stat.nempty[Q_MID]) begin
                    w_cmd.sel = Q_MID;
                end else begin
                    w_cmd.sel = Q_LOW;
                end
                n_state = (|w_stat.nempty) ? S_RD : S_OUT;
            end
            S_RD: begin
                n_next_task  = w_rdata;
                n_next_valid = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_task  <= n_next_task;
        r_next_valid <= n_next_valid;
        if (w_accept) begin
            r_op    <= i_opcode;
            r_id    <= i_task_id;
            r_blk   <= i_task_blocked;
            r_base  <= i_base_level;
            r_start <= i_start_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TW; i++) begin
                r_lvl_tbl[i]  <= LVL_1;
                r_base_tbl[i] <= LVL_1;
            end
        end else begin
            if (w_lvl_we) begin
                r_lvl_tbl[w_tidx] <= w_lvl_wdata;
            end
            if (w_base_we) begin
                r_base_tbl[w_tidx] <= clamp_level(r_base);
            end
        end
    end

    mfs_queue #(
        .NUM_TASKS(NUM_TASKS)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_wdata(r_id),
        .o_stat (w_stat),
        .o_rdata(w_rdata)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_next_task  = r_next_task;
    assign o_next_valid = r_next_valid;

endmodule

### src/mfs_ram.sv
// mfs_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mfs_queue.sv
// mfs_queue: three ready FIFOs of task ids with one shared pointer step unit.
// Depends on mfs_pkg and mfs_ram.
`timescale 1ns / 1ps

module mfs_queue #(
    parameter int NUM_TASKS = mfs_pkg::NUM_TASKS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mfs_pkg::t_qcmd          i_cmd,
    input  logic [mfs_pkg::ID_W-1:0] i_wdata,
    output mfs_pkg::t_qstat         o_stat,
    output logic [mfs_pkg::ID_W-1:0] o_rdata
);
    import mfs_pkg::*;

    localparam int AW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);

    logic [AW-1:0] r_head [NQ];
    logic [AW-1:0] r_tail [NQ];
    logic [CW-1:0] r_cnt  [NQ];
    t_qsel         r_rsel;

    logic [ID_W-1:0] w_rdata [NQ];
    logic [NQ-1:0]   w_nempty;
    logic [NQ-1:0]   w_full;

    // shared step unit
    logic [AW-1:0] w_ptr;
    logic [AW-1:0] w_ptr_nxt;
    logic [CW-1:0] w_cnt_nxt;
    logic          w_go;

    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            w_nempty[i] = (r_cnt[i] != '0);
            w_full[i]   = (r_cnt[i] == CW'(NUM_TASKS));
        end
    end

    assign o_stat.nempty = w_nempty;
    assign o_stat.full   = w_full;

    always_comb begin
        w_ptr     = i_cmd.push ? r_tail[i_cmd.sel] : r_head[i_cmd.sel];
        w_ptr_nxt = (w_ptr == AW'(NUM_TASKS - 1)) ? '0 : w_ptr + AW'(1);
        w_cnt_nxt = i_cmd.push ? r_cnt[i_cmd.sel] + CW'(1) : r_cnt[i_cmd.sel] - CW'(1);
        // pushes into a full queue are dropped, pops from an empty one ignored
        w_go      = i_cmd.en && (i_cmd.sel != 2'd3) &&
                    (i_cmd.push ? !w_full[i_cmd.sel] : w_nempty[i_cmd.sel]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NQ; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_rsel <= Q_LOW;
        end else if (w_go) begin
            r_cnt[i_cmd.sel] <= w_cnt_nxt;
            if (i_cmd.push) begin
                r_tail[i_cmd.sel] <= w_ptr_nxt;
            end else begin
                r_head[i_cmd.sel] <= w_ptr_nxt;
                r_rsel            <= i_cmd.sel;
            end
        end
    end

    for (genvar g = 0; g < NQ; g++) begin : g_fifo
        mfs_ram #(
            .WIDTH(ID_W),
            .DEPTH(NUM_TASKS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_go && i_cmd.push && (i_cmd.sel == t_qsel'(g))),
            .i_waddr(r_tail[g]),
            .i_wdata(i_wdata),
            .i_raddr(r_head[g]),
            .o_rdata(w_rdata[g])
        );
    end

    // read data of the queue popped last; valid the cycle after the pop
    always_comb begin
        case (r_rsel)
            Q_MID:   o_rdata = w_rdata[1];
            Q_HIGH:  o_rdata = w_rdata[2];
            default: o_rdata = w_rdata[0];
        endcase
    end

endmodule

### tb/dispatch_checker.sv
// dispatch_checker: watches the request and result channels of the scheduler,
// keeps its own copy of the ready queues and level tables, and compares each result.
// Depends on mfs_pkg.
`timescale 1ns / 1ps

module dispatch_checker #(
    parameter int NUM_TASKS = mfs_pkg::NUM_TASKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [mfs_pkg::OP_W-1:0]   i_opcode,
    input  logic [mfs_pkg::ID_W-1:0]   i_task_id,
    input  logic                       i_task_blocked,
    input  logic [mfs_pkg::LVL_W-1:0]  i_base_level,
    input  logic [mfs_pkg::LVL_W-1:0]  i_start_level,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    input  logic [mfs_pkg::ID_W-1:0]   i_next_task,
    input  logic                       i_next_valid,
    output int                         o_errors,
    output int                         o_pending
);

    import mfs_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] task_id;
        logic            found;
    } t_dispatch;

    // ready queues, index is level minus one
    logic [ID_W-1:0]  rq_mem [NQ][NUM_TASKS];
    int               rq_head [NQ];
    int               rq_cnt [NQ];
    logic [LVL_W-1:0] cur_lvl [NUM_TASKS];
    logic [LVL_W-1:0] base_lvl [NUM_TASKS];

    t_dispatch        due_q [$];

    // push into a full queue is dropped
    function automatic void rq_push(input t_qsel q, input logic [ID_W-1:0] id);
        if (rq_cnt[q] < NUM_TASKS) begin
            rq_mem[q][(rq_head[q] + rq_cnt[q]) % NUM_TASKS] = id;
            rq_cnt[q]++;
        end
    endfunction

    function automatic logic [LVL_W-1:0] lvl_or_one(input logic [LVL_W-1:0] v);
        return (v == '0) ? LVL_1 : v;
    endfunction

    function automatic t_dispatch model_request(
        input logic [OP_W-1:0]  op,
        input logic [ID_W-1:0]  id,
        input logic             blk,
        input logic [LVL_W-1:0] base,
        input logic [LVL_W-1:0] start
    );
        t_dispatch        r;
        logic [LVL_W-1:0] nxt;
        int               q;
        bit               hit;
        r   = '0;
        hit = 1'b0;
        if (op == OP_SCHED) begin
            // running task goes back one level down, or to its base from level 1
            if (!blk && id != '0 && int'(id) < NUM_TASKS) begin
                case (cur_lvl[id])
                    LVL_3:   nxt = LVL_2;
                    LVL_2:   nxt = LVL_1;
                    default: nxt = base_lvl[id];
                endcase
                if (nxt == '0) nxt = LVL_1;
                cur_lvl[id] = nxt;
                rq_push(t_qsel'(nxt - 1'b1), id);
            end
            for (q = NQ - 1; q >= 0; q--) begin
                if (!hit && rq_cnt[q] != 0) begin
                    r.task_id  = rq_mem[q][rq_head[q]];
                    r.found    = 1'b1;
                    rq_head[q] = (rq_head[q] + 1) % NUM_TASKS;
                    rq_cnt[q]--;
                    hit        = 1'b1;
                end
            end
        end else if (op == OP_WAKE) begin
            if (int'(id) < NUM_TASKS) rq_push(Q_HIGH, id);
        end else if (op == OP_SETUP) begin
            if (int'(id) < NUM_TASKS) begin
                base_lvl[id] = lvl_or_one(base);
                cur_lvl[id]  = lvl_or_one(start);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dispatch want;
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                rq_head[q] = 0;
                rq_cnt[q]  = 0;
            end
            for (int t = 0; t < NUM_TASKS; t++) begin
                cur_lvl[t]  = LVL_1;
                base_lvl[t] = LVL_1;
            end
            due_q.delete();
        end else begin
            // result first: it always belongs to an earlier request
            if (i_rsp_valid && i_rsp_ready) begin
                if (due_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with none expected: next_task %0d next_valid %0d",
                             $time, i_next_task, i_next_valid);
                end else begin
                    want = due_q.pop_front();
                    if (i_next_task !== want.task_id) begin
                        o_errors++;
                        $display("%0t: next_task expected %0d actual %0d",
                                 $time, want.task_id, i_next_task);
                    end
                    if (i_next_valid !== want.found) begin
                        o_errors++;
                        $display("%0t: next_valid expected %0d actual %0d",
                                 $time, want.found, i_next_valid);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                due_q.push_back(model_request(i_opcode, i_task_id, i_task_blocked,
                                              i_base_level, i_start_level));
            end
        end
        o_pending = due_q.size();
    end

endmodule

### tb/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for multilevel_feedback_scheduler.
// Depends on mfs_pkg, the scheduler RTL and dispatch_checker.
`timescale 1ns / 1ps

module tb_top;

    import mfs_pkg::*;

    localparam int NUM_TASKS = 16;
    localparam int ITEMS     = 1400;
    localparam int LIMIT     = 1_000_000;  // cycles; slowest legal run is well under this
    localparam int SETTLE    = 12;         // cycles waited after the drain for any stray result

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_ready;
    logic [OP_W-1:0]   req_op      = OP_NOP;
    logic [ID_W-1:0]   req_id      = '0;
    logic              req_blocked = 1'b0;
    logic [LVL_W-1:0]  req_base    = '0;
    logic [LVL_W-1:0]  req_start   = '0;
    logic              rsp_valid;
    logic              rsp_ready   = 1'b0;
    logic [ID_W-1:0]   rsp_task;
    logic              rsp_found;

    int                errors;
    int                pending;
    int                cycles      = 0;
    int                sent        = 0;
    bit                calm        = 1'b0;  // stretch with no idling on either side
    int                stall_left  = 0;
    logic [ID_W-1:0]   running     = '0;    // last task dispatched, used as "current"

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multilevel_feedback_scheduler #(
        .NUM_TASKS (NUM_TASKS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_ready        (req_ready),
        .i_opcode       (req_op),
        .i_task_id      (req_id),
        .i_task_blocked (req_blocked),
        .i_base_level   (req_base),
        .i_start_level  (req_start),
        .o_valid        (rsp_valid),
        .i_ready        (rsp_ready),
        .o_next_task    (rsp_task),
        .o_next_valid   (rsp_found)
    );

    dispatch_checker #(
        .NUM_TASKS (NUM_TASKS)
    ) chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_opcode       (req_op),
        .i_task_id      (req_id),
        .i_task_blocked (req_blocked),
        .i_base_level   (req_base),
        .i_start_level  (req_start),
        .i_rsp_valid    (rsp_valid),
        .i_rsp_ready    (rsp_ready),
        .i_next_task    (rsp_task),
        .i_next_valid   (rsp_found),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Track the dispatched task so schedule requests can name it as the
    // running one, the way a real kernel would.
    always @(posedge clk) begin
        if (rsp_valid && rsp_ready && rsp_found) running <= rsp_task;
    end

    // Mostly short gaps, some medium, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure, changed on the falling edge only.
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_ready  <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // One request transfer. Entered and left at a falling edge; valid is
    // only lowered when a gap follows, so back-to-back items keep it high.
    task automatic issue(
        input logic [OP_W-1:0]  op,
        input logic [ID_W-1:0]  id,
        input logic             blk,
        input logic [LVL_W-1:0] base,
        input logic [LVL_W-1:0] start
    );
        int gap;
        req_valid   <= 1'b1;
        req_op      <= op;
        req_id      <= id;
        req_blocked <= blk;
        req_base    <= base;
        req_start   <= start;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        sent++;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial begin
        int                kind;
        int                n;
        int                r;
        logic [ID_W-1:0]   id;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        issue(OP_SCHED, 4'd0,  1'b0, 2'd0, 2'd0);  // all queues empty
        issue(OP_SCHED, 4'd5,  1'b0, 2'd3, 2'd3);  // requeue at base level, dispatch it
        issue(OP_SCHED, 4'd5,  1'b1, 2'd0, 2'd0);  // blocked: nothing requeued, empty
        issue(OP_SETUP, 4'd15, 1'b1, 2'd3, 2'd3);
        issue(OP_SETUP, 4'd1,  1'b0, 2'd0, 2'd0);  // level zero stored as level 1
        issue(OP_SETUP, 4'd2,  1'b0, 2'd2, 2'd3);
        issue(OP_SETUP, 4'd10, 1'b0, 2'd3, 2'd1);
        issue(OP_WAKE,  4'd15, 1'b0, 2'd1, 2'd2);
        issue(OP_WAKE,  4'd15, 1'b1, 2'd2, 2'd1);  // same task queued twice
        issue(OP_WAKE,  4'd2,  1'b0, 2'd0, 2'd3);
        issue(OP_NOP,   4'd7,  1'b1, 2'd3, 2'd3);
        issue(OP_SCHED, 4'd15, 1'b1, 2'd0, 2'd0);
        issue(OP_SCHED, 4'd15, 1'b0, 2'd0, 2'd0);  // level 3 drops to 2
        issue(OP_SCHED, 4'd0,  1'b0, 2'd0, 2'd0);  // idle task is never requeued
        issue(OP_SCHED, 4'd2,  1'b0, 2'd0, 2'd0);
        issue(OP_SCHED, 4'd15, 1'b0, 2'd0, 2'd0);  // level 2 drops to 1
        issue(OP_SCHED, 4'd2,  1'b0, 2'd0, 2'd0);
        issue(OP_SCHED, 4'd10, 1'b0, 2'd0, 2'd0);  // level 1 returns to base 3
        issue(OP_SCHED, 4'd10, 1'b0, 2'd0, 2'd0);
        issue(OP_SCHED, 4'd1,  1'b0, 2'd0, 2'd0);
        issue(OP_SCHED, 4'd0,  1'b1, 2'd0, 2'd0);
        issue(OP_SCHED, 4'd0,  1'b0, 2'd0, 2'd0);
        issue(OP_SCHED, 4'd0,  1'b0, 2'd0, 2'd0);

        // ---- random part, in episodes ----
        while (sent < ITEMS + 23) begin
            calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // mixed traffic: setups, wakes, schedules mostly of the running task, noise
                n = $urandom_range(10, 40);
                repeat (n) begin
                    r  = $urandom_range(0, 99);
                    id = ($urandom_range(0, 9) < 6) ? running : ID_W'($urandom_range(0, 15));
                    if (r < 8)
                        issue(OP_SETUP, ID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              LVL_W'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 3)));
                    else if (r < 38)
                        issue(OP_WAKE, ID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              LVL_W'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 3)));
                    else if (r < 96)
                        issue(OP_SCHED, id, 1'($urandom_range(0, 4) == 0),
                              LVL_W'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 3)));
                    else
                        issue(OP_NOP, ID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              LVL_W'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 3)));
                end
            end else begin
                // flood: fill the top queue, at times past its depth, then drain it so tasks sink
                // through the levels and the lower queues fill up too
                n = $urandom_range(12, 20);
                repeat (n)
                    issue(OP_WAKE, ID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          LVL_W'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 3)));
                n = $urandom_range(16, 48);
                repeat (n)
                    issue(OP_SCHED, running, 1'($urandom_range(0, 9) == 0),
                          LVL_W'($urandom_range(0, 3)), LVL_W'($urandom_range(0, 3)));
            end
        end
        req_valid <= 1'b0;
        calm = 1'b0;

        // drain, then give the block time to show any stray result
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
src/mfs_pkg.sv
src/mfs_ram.sv
src/mfs_queue.sv
src/multilevel_feedback_scheduler.sv
tb/dispatch_checker.sv
tb/tb_top.sv
